>>> hdl/cmbpg_pkg.sv
// Shared types and constants for the chaotic map bit-pair generator.
// Holds the controller state enum, command/status structs and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cmbpg_pkg;

    // Fixed-point one in Q2.30.
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

    // Reset values of the gain registers (unsigned Q3.29).
    localparam logic [31:0] GAIN_FIRST_RST  = 32'd1014876613;
    localparam logic [31:0] GAIN_SECOND_RST = 32'd211476388;

    // Remainder unit: one quotient bit per cycle.
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_SEED_FIRST  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SEED_SECOND = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_FIRST  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_SECOND = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_EMIT
    } ctrl_state_t;

    // Commands from the controller.
    typedef struct packed {
        logic accept;     // input transaction taken this cycle
        logic map_step;   // advance both chaotic states
        logic mul_step;   // register a*b and a+b
        logic div_start;  // load the remainder unit
        logic emit;       // load the output register
    } ctrl_cmd_t;

    // Status back to the controller.
    typedef struct packed {
        logic den_zero;   // divisor 1 - a*b is zero
        logic div_busy;   // remainder unit still iterating
        logic rem_zero;   // fractional part is zero
        logic out_free;   // output register can take a result
    } ctrl_status_t;

endpackage

`default_nettype wire

>>> hdl/cmbpg_div.sv
// Iterative restoring remainder unit, one bit per cycle.
// Depends on cmbpg_pkg for the step count.
`timescale 1ns / 1ps
`default_nettype none

module cmbpg_div
    import cmbpg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic [31:0]      rem,
    output logic [31:0]      den
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]          rem_reg, rem_next;
    logic [31:0]          dvd_reg, dvd_next;
    logic [31:0]          div_reg, div_next;
    logic [32:0]          partial;
    logic                 fits;

    assign partial = {rem_reg, dvd_reg[31]};
    assign fits    = partial >= {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? 32'(partial - {1'b0, div_reg}) : partial[31:0];
            dvd_next = {dvd_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;
    assign den  = div_reg;

    // The restoring step keeps the partial remainder below the divisor.
    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < div_reg))
        else $error("remainder reached divisor");

    // The unit does not stop before its last step.
    a_full_run: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg != DIV_CNT_W'(DIV_STEPS - 1) && !start) |=> busy_reg)
        else $error("remainder unit stopped early");

endmodule

`default_nettype wire

>>> hdl/cmbpg_datapath.sv
// Datapath: configuration registers, the two chaotic maps, the a*b product,
// the divisor and remainder unit, and the bit-pair quantizer. Uses cmbpg_pkg, cmbpg_div.
`timescale 1ns / 1ps
`default_nettype none

module cmbpg_datapath
    import cmbpg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [31:0]           cfg_data,
    input  wire logic                  restart,
    input  wire ctrl_cmd_t             cmd,
    output logic                       den_zero,
    output logic                       div_busy,
    output logic                       rem_zero,
    output logic                       bit_high,
    output logic                       bit_low
);

    logic signed [31:0] seed_first_reg, seed_second_reg;
    logic [31:0]        gain_first_reg, gain_second_reg;
    logic signed [31:0] state_first_reg, state_first_next;
    logic signed [31:0] state_second_reg, state_second_next;
    logic signed [31:0] ab30_reg, ab30_next;
    logic signed [32:0] num_reg, num_next;

    logic signed [64:0] prod_first, prod_second;
    logic signed [31:0] map_first, map_second;
    logic signed [63:0] prod_ab;
    logic signed [32:0] den_wide;
    logic [31:0]        den_in;
    logic [31:0]        unum;
    logic [31:0]        rem;
    logic [31:0]        den;
    logic [33:0]        r4, d1, d2, d3;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_first_reg  <= '0;
            seed_second_reg <= '0;
            gain_first_reg  <= GAIN_FIRST_RST;
            gain_second_reg <= GAIN_SECOND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SEED_FIRST:  seed_first_reg  <= cfg_data;
                REG_SEED_SECOND: seed_second_reg <= cfg_data;
                REG_GAIN_FIRST:  gain_first_reg  <= cfg_data;
                REG_GAIN_SECOND: gain_second_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // x' = 1 - 2*frac(x*g); the fraction is bits [58:29] of the Q.59 product.
    assign prod_first  = 65'(state_first_reg) * 65'($signed({1'b0, gain_first_reg}));
    assign prod_second = 65'(state_second_reg) * 65'($signed({1'b0, gain_second_reg}));
    assign map_first   = ONE_Q30 - $signed({1'b0, prod_first[58:29], 1'b0});
    assign map_second  = ONE_Q30 - $signed({1'b0, prod_second[58:29], 1'b0});

    assign prod_ab   = 64'(state_first_reg) * 64'(state_second_reg);

    always_comb
    begin
        state_first_next  = state_first_reg;
        state_second_next = state_second_reg;
        ab30_next         = ab30_reg;
        num_next          = num_reg;
        if (cmd.accept && restart)
        begin
            state_first_next  = seed_first_reg;
            state_second_next = seed_second_reg;
        end
        else if (cmd.map_step)
        begin
            state_first_next  = map_first;
            state_second_next = map_second;
        end
        if (cmd.mul_step)
        begin
            // Floor of a*b to Q.30; the magnitude never exceeds one.
            ab30_next = prod_ab[61:30];
            num_next  = 33'(state_first_reg) + 33'(state_second_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_first_reg  <= '0;
            state_second_reg <= '0;
        end
        else
        begin
            state_first_reg  <= state_first_next;
            state_second_reg <= state_second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ab30_reg <= ab30_next;
        num_reg  <= num_next;
    end

    // Divisor 1 - a*b lies in [0, 2]; numerator magnitude is at most two.
    assign den_wide = 33'(ONE_Q30) - 33'(ab30_reg);
    assign den_in   = den_wide[31:0];
    assign den_zero = (den_wide == '0);
    assign unum     = num_reg[32] ? 32'(-num_reg) : num_reg[31:0];

    cmbpg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (unum),
        .divisor  (den_in),
        .busy     (div_busy),
        .rem      (rem),
        .den      (den)
    );

    // Quarter of the fraction, tested exactly on 4*rem against multiples of den.
    assign r4 = {rem, 2'b00};
    assign d1 = {2'b00, den};
    assign d2 = {1'b0, den, 1'b0};
    assign d3 = d1 + d2;

    assign rem_zero = (rem == '0);
    assign bit_high = r4 > d2;
    assign bit_low  = bit_high ? (r4 > d3) : (r4 > d1);

endmodule

`default_nettype wire

>>> hdl/cmbpg_ctrl.sv
// Controller state machine that sequences one item through the datapath.
// Depends on cmbpg_pkg for the state enum and command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module cmbpg_ctrl
    import cmbpg_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire ctrl_status_t status,
    output ctrl_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_PREP;
            ST_PREP: state_next = status.den_zero ? ST_IDLE : ST_DIV;
            ST_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.rem_zero || status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_MAP:  cmd.map_step = 1'b1;
            ST_MUL:  cmd.mul_step = 1'b1;
            ST_PREP: cmd.div_start = !status.den_zero;
            ST_DIV:  ;
            ST_EMIT: cmd.emit = !status.rem_zero && status.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A result is never loaded over one that is still waiting.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result emitted into a full output register");

    // Starting the remainder unit makes it busy on the next cycle.
    a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (status.div_busy && state_reg == ST_DIV))
        else $error("remainder unit did not start");

    // A divide only starts on a nonzero divisor.
    a_no_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.den_zero)
        else $error("divide started with zero divisor");

endmodule

`default_nettype wire

>>> hdl/chaotic_map_bit_pair_generator.sv
// Top level of the chaotic map bit-pair generator: controller, datapath and
// output register. Depends on cmbpg_pkg, cmbpg_ctrl and cmbpg_datapath.
//
// Usage: each input transaction on the s_ group is one step of two coupled
// chaotic maps. Bit 0 of s_tdata is restart; when set, both states reload
// from the seed registers before the step. A step yields at most one result
// transaction on the m_ group carrying a bit pair (bit_high in m_tdata[0],
// bit_low in m_tdata[1]). Steps whose divisor 1 - a*b or whose fractional
// part is zero produce no result, but the states still advance.
// Flow: an item is accepted, then passes through the map, product and
// divisor stages and the 32-step bit-serial remainder unit before its
// result is loaded into the output register. The block takes a new item
// only once the controller is back in idle after the last one; a step with
// a zero divisor returns to idle straight from the divisor stage.
// The output register lets the block accept the next item while a result
// still waits; if the receiver stalls past the next result, the controller
// holds that result in its final state until the register frees up.
// Reset clears both states, the seeds and restores the default gains.
// Configuration writes (cfg_we, cfg_addr, cfg_data) must be made while idle.
`timescale 1ns / 1ps
`default_nettype none

module chaotic_map_bit_pair_generator
    import cmbpg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write port.
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [31:0]           cfg_data,
    // Input stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [0] restart, [7:1] zero
    // Output stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata    // [0] bit_high, [1] bit_low, [7:2] zero
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    logic         bit_high, bit_low;
    logic         m_tvalid_reg, m_tvalid_next;
    logic [1:0]   bits_reg, bits_next;

    cmbpg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cmbpg_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .restart  (s_tdata[0]),
        .cmd      (cmd),
        .den_zero (status.den_zero),
        .div_busy (status.div_busy),
        .rem_zero (status.rem_zero),
        .bit_high (bit_high),
        .bit_low  (bit_low)
    );

    // The output register is free when empty or when its transaction completes now.
    assign status.out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        bits_next     = bits_reg;
        if (cmd.emit)
        begin
            m_tvalid_next = 1'b1;
            bits_next     = {bit_low, bit_high};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, bits_reg};

endmodule

`default_nettype wire

>>> sim/chaotic_map_bit_pair_generator_checker.sv
// Scoreboard for the chaotic map bit-pair generator: mirrors the register file,
// advances both chaotic states per accepted step and checks every bit pair.
// Depends on cmbpg_pkg for the register indexes, reset gains and Q2.30 one.
`timescale 1ns / 1ps

module chaotic_map_bit_pair_generator_checker
    import cmbpg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [31:0]           cfg_data,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [7:0]            s_tdata,   // [0] restart, [7:1] zero
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [7:0]            m_tdata,   // [0] bit_high, [1] bit_low, [7:2] zero
    output int                         error_count,
    output int                         pending_count
);

    typedef struct packed {
        logic bit_high;
        logic bit_low;
    } bit_pair_t;

    logic signed [31:0] seed_a;
    logic signed [31:0] seed_b;
    logic        [31:0] gain_a;
    logic        [31:0] gain_b;
    logic signed [31:0] orbit_a;
    logic signed [31:0] orbit_b;

    bit_pair_t pair_q[$];

    // One map iteration: x' = 1 - 2*frac(x*g), frac taken from bits 58..29
    // of the exact two's complement product, i.e. rounded toward minus infinity.
    function automatic logic signed [31:0] advance_map(input logic signed [31:0] x,
                                                       input logic [31:0] g);
        logic signed [63:0] xs;
        logic signed [63:0] gs;
        logic signed [63:0] prod;
        logic        [29:0] frac;
        xs   = x;
        gs   = {32'b0, g};
        prod = xs * gs;
        frac = prod[58:29];
        return ONE_Q30 - $signed({1'b0, frac, 1'b0});
    endfunction

    // Forms (a+b)/(1-ab) and bins the fractional part by exact remainder tests.
    // Returns 0 when the divisor or the remainder is zero.
    function automatic bit quantize_pair(input logic signed [31:0] a,
                                         input logic signed [31:0] b,
                                         output bit_pair_t pair);
        logic signed [63:0] as64;
        logic signed [63:0] bs64;
        logic signed [63:0] one64;
        logic signed [63:0] ab;
        logic signed [63:0] num;
        logic signed [63:0] den;
        logic        [63:0] unum;
        logic        [63:0] uden;
        logic        [63:0] rem;
        logic        [63:0] r4;
        pair  = '0;
        as64  = a;
        bs64  = b;
        one64 = ONE_Q30;
        ab    = as64 * bs64;
        num   = as64 + bs64;
        den   = one64 - (ab >>> 30);
        if (den <= 0)
            return 1'b0;
        unum = (num < 0) ? $unsigned(-num) : $unsigned(num);
        uden = $unsigned(den);
        rem  = unum % uden;
        if (rem == 0)
            return 1'b0;
        r4 = rem << 2;
        if (r4 <= uden)
            pair = '{bit_high: 1'b0, bit_low: 1'b0};
        else if (r4 <= 2 * uden)
            pair = '{bit_high: 1'b0, bit_low: 1'b1};
        else if (r4 <= 3 * uden)
            pair = '{bit_high: 1'b1, bit_low: 1'b0};
        else
            pair = '{bit_high: 1'b1, bit_low: 1'b1};
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        bit_pair_t want;
        bit_pair_t got;
        if (!rst_n)
        begin
            seed_a  = '0;
            seed_b  = '0;
            gain_a  = GAIN_FIRST_RST;
            gain_b  = GAIN_SECOND_RST;
            orbit_a = '0;
            orbit_b = '0;
            pair_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_SEED_FIRST:  seed_a = cfg_data;
                    REG_SEED_SECOND: seed_b = cfg_data;
                    REG_GAIN_FIRST:  gain_a = cfg_data;
                    REG_GAIN_SECOND: gain_b = cfg_data;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tdata[0])
                begin
                    orbit_a = seed_a;
                    orbit_b = seed_b;
                end
                orbit_a = advance_map(orbit_a, gain_a);
                orbit_b = advance_map(orbit_b, gain_b);
                if (quantize_pair(orbit_a, orbit_b, want))
                    pair_q.push_back(want);
            end

            if (m_tvalid && m_tready)
            begin
                got = '{bit_high: m_tdata[0], bit_low: m_tdata[1]};
                if (pair_q.size() == 0)
                begin
                    $error("unexpected bit pair: bit_high %0d, bit_low %0d",
                           got.bit_high, got.bit_low);
                    error_count++;
                end
                else
                begin
                    want = pair_q.pop_front();
                    if (got.bit_high !== want.bit_high)
                    begin
                        $error("bit_high mismatch: expected %0d, actual %0d",
                               want.bit_high, got.bit_high);
                        error_count++;
                    end
                    if (got.bit_low !== want.bit_low)
                    begin
                        $error("bit_low mismatch: expected %0d, actual %0d",
                               want.bit_low, got.bit_low);
                        error_count++;
                    end
                end
            end
        end
        pending_count = pair_q.size();
    end

endmodule

>>> sim/chaotic_map_bit_pair_generator_tb.sv
// Testbench top for the chaotic map bit-pair generator: clock, reset, register
// writes, step and result traffic, and the final verdict.
// Depends on cmbpg_pkg, the block itself and chaotic_map_bit_pair_generator_checker.
`timescale 1ns / 1ps

module chaotic_map_bit_pair_generator_tb;
    import cmbpg_pkg::*;

    // Number of random phases and steps per phase; each phase starts with a
    // fresh register setting and a restart transaction.
    localparam int RAND_PHASES     = 12;
    localparam int STEPS_PER_PHASE = 96;
    // The idle cycles after the last expected result cover any step still in
    // flight, even one that yields no result.
    localparam int SETTLE_CYCLES   = 48;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int STALL_CYCLES    = 300;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [31:0]           cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [0] restart, [7:1] zero
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;          // [0] bit_high, [1] bit_low, [7:2] zero

    int error_count;
    int pending_count;

    // Idle percentages of the sender and the receiver for the current phase.
    int tx_idle_pct = 26;
    int rx_idle_pct = 80;

    // A one-time request for the receiver to hold off for a long stretch.
    logic pressure_req  = 1'b0;
    bit   pressure_done = 1'b0;
    int   stall_left    = 0;

    always #4 clk = ~clk;

    chaotic_map_bit_pair_generator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    chaotic_map_bit_pair_generator_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // Offers one step transaction. It is entered and left at a falling edge;
    // tvalid stays high on return so back-to-back steps keep it asserted.
    task automatic send_step(input bit restart);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Registers may only change while the block is idle: every expected result
    // must have been taken, and a trailing step without a result must be done.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes all four registers in consecutive cycles.
    task automatic write_regs(input logic [31:0] seed_first, input logic [31:0] seed_second,
                              input logic [31:0] gain_first, input logic [31:0] gain_second);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_addr <= REG_SEED_FIRST;
        cfg_data <= seed_first;
        @(negedge clk);
        cfg_addr <= REG_SEED_SECOND;
        cfg_data <= seed_second;
        @(negedge clk);
        cfg_addr <= REG_GAIN_FIRST;
        cfg_data <= gain_first;
        @(negedge clk);
        cfg_addr <= REG_GAIN_SECOND;
        cfg_data <= gain_second;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    // Seeds lean toward the corners of the Q2.30 range and plus or minus one.
    function automatic logic [31:0] pick_seed();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h4000_0000;
            3:       return 32'hC000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Gains include zero, all ones and the reset value now and then.
    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return GAIN_FIRST_RST;
            default: return $urandom();
        endcase
    endfunction

    // Receiver: random back-pressure, plus one long hold-off counted here so
    // that the output register and the controller both fill and s_tready drops.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else if (pressure_req && !pressure_done)
            begin
                pressure_done = 1'b1;
                stall_left    = STALL_CYCLES - 1;
                m_tready     <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int phase;
        int step;
        int drain_cycles;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        // Directed part, with the sender lightly and the receiver heavily idle.
        // From the zero reset state both maps land on one, so the divisor
        // 1 - a*b is zero and the first step yields nothing.
        send_step(1'b0);
        send_step(1'b0);
        send_step(1'b1);
        send_step(1'b0);

        // Extreme seeds with the largest and the zero gain.
        write_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_step(1'b1);
        repeat (3) send_step(1'b0);

        write_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        send_step(1'b1);
        repeat (2) send_step(1'b0);

        // Zero gain pins the first state at one; seed one times gain one half
        // puts the second state at zero, so the quotient is exactly one and
        // the fractional part is zero. The next step hits a zero divisor.
        write_regs(32'h1234_5678, 32'h4000_0000, 32'h0000_0000, 32'h1000_0000);
        send_step(1'b1);
        send_step(1'b0);

        // Small seeds of opposite sign under the reset gains.
        write_regs(32'h0CCC_CCCD, 32'hF333_3333, GAIN_FIRST_RST, GAIN_SECOND_RST);
        send_step(1'b1);
        repeat (5) send_step(1'b0);

        // Random part. The first third idles the receiver hard, the second
        // idles the sender hard, the last runs without idling and carries the
        // long receiver hold-off.
        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            write_regs(pick_seed(), pick_seed(), pick_gain(), pick_gain());
            if (phase < RAND_PHASES / 3)
            begin
                tx_idle_pct  = 26;
                rx_idle_pct <= 80;
            end
            else if (phase < 2 * RAND_PHASES / 3)
            begin
                tx_idle_pct  = 80;
                rx_idle_pct <= 26;
            end
            else
            begin
                tx_idle_pct  = 0;
                rx_idle_pct <= 0;
                if (phase == 2 * RAND_PHASES / 3)
                    pressure_req <= 1'b1;
            end
            send_step(1'b1);
            for (step = 1; step < STEPS_PER_PHASE; step++)
                send_step($urandom_range(0, 15) == 0);
        end

        // Let every result come out, then give the block time to show any
        // stray result beyond the expected ones.
        s_tvalid <= 1'b0;
        drain_cycles = 0;
        while (pending_count != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain_cycles++;
        end
        repeat (2 * SETTLE_CYCLES) @(negedge clk);

        if (error_count == 0 && pending_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #6_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
